>>> hw/rtl/nlcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_pkg
// shared types, constants and helper functions of the nmea line checker
// ----------------------------------------------------------------------------
package nlcc_pkg;

  localparam int LineBufBytes = 128;
  localparam int FillW        = $clog2(LineBufBytes);
  localparam int LenW         = 7;
  localparam int HeaderLen    = 6;

  localparam logic [7:0] NlByte   = 8'h0A;
  localparam logic [7:0] StarByte = 8'h2A;
  localparam logic [7:0] ZeroByte = 8'h00;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } nlcc_byte_t;

  typedef struct packed {
    logic            checksum_ok;
    logic            is_gga;
    logic            star_found;
    logic [LenW-1:0] line_length;
    logic [7:0]      computed_sum;
    logic [7:0]      received_sum;
    logic            full_end;
  } nlcc_result_t;

  typedef struct packed {
    logic         push;
    nlcc_result_t res;
  } nlcc_push_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nlcc_hex_t;

  function automatic logic [7:0] gga_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic nlcc_hex_t hex_digit(input logic [7:0] c);
    nlcc_hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> hw/rtl/nmea_line_checksum_checker_core.sv
// path: a line-ending byte is taken into the input register, then the line state
// pushes its result into the result buffer, which drives the outputs
// throughput: one byte per cycle while the result buffer has room; the two-entry
// buffer keeps bytes flowing while one result waits under output stall
// reset: rst_ni is asynchronous, active low, and clears line state and all valids
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_line_checksum_checker_core
// frames serial bytes into lines and checks the nmea sentence checksum
// ----------------------------------------------------------------------------
module nmea_line_checksum_checker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      checksum_ok_o,
  output logic                      is_gga_o,
  output logic                      star_found_o,
  output logic [nlcc_pkg::LenW-1:0] line_length_o,
  output logic [7:0]                computed_sum_o,
  output logic [7:0]                received_sum_o,
  output logic                      full_end_o
);
  import nlcc_pkg::*;

  nlcc_byte_t   byte_s;
  nlcc_push_t   push_s;
  nlcc_result_t res_s;
  logic         advance;
  logic         room;

  nlcc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .byte_o     (byte_s)
  );

  nlcc_line_state u_line_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_s),
    .room_i    (room),
    .advance_o (advance),
    .push_o    (push_s)
  );

  nlcc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_s),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_s)
  );

  assign checksum_ok_o  = res_s.checksum_ok;
  assign is_gga_o       = res_s.is_gga;
  assign star_found_o   = res_s.star_found;
  assign line_length_o  = res_s.line_length;
  assign computed_sum_o = res_s.computed_sum;
  assign received_sum_o = res_s.received_sum;
  assign full_end_o     = res_s.full_end;

endmodule

>>> hw/rtl/nlcc_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_in_reg
// input register for received bytes, holds one byte until the core takes it
// ----------------------------------------------------------------------------
module nlcc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               advance_i,
  output nlcc_pkg::nlcc_byte_t byte_o
);
  import nlcc_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (accept) begin
      valid_d = 1'b1;
      data_d  = rx_byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign byte_o.valid = valid_q;
  assign byte_o.data  = data_q;

endmodule

>>> hw/rtl/nlcc_line_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_line_state
// per-line state: fill count, running xor, star and hex tracking, header match
// ----------------------------------------------------------------------------
module nlcc_line_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nlcc_pkg::nlcc_byte_t byte_i,
  input  logic                 room_i,
  output logic                 advance_o,
  output nlcc_pkg::nlcc_push_t push_o
);
  import nlcc_pkg::*;

  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       xor_q, xor_d;
  logic             star_q, star_d;
  logic             star_ok_q, star_ok_d;
  logic [7:0]       hex_q, hex_d;
  logic             hex_act_q, hex_act_d;
  logic             hdr_q, hdr_d;
  logic             zero_q, zero_d;

  logic       is_nl;
  logic       full;
  logic [7:0] c;
  nlcc_hex_t  hd;

  assign advance_o = byte_i.valid && room_i;
  assign c         = byte_i.data;
  assign is_nl     = (c == NlByte);
  assign full      = (fill_q >= FillW'(LineBufBytes - 1));
  assign hd        = hex_digit(c);

  always_comb begin
    fill_d    = fill_q;
    xor_d     = xor_q;
    star_d    = star_q;
    star_ok_d = star_ok_q;
    hex_d     = hex_q;
    hex_act_d = hex_act_q;
    hdr_d     = hdr_q;
    zero_d    = zero_q;
    push_o    = '0;
    if (advance_o) begin
      if (!is_nl && !full) begin
        fill_d = fill_q + FillW'(1);
        if (!zero_q) begin
          if (fill_q < FillW'(HeaderLen) && c != gga_char(fill_q[2:0])) begin
            hdr_d = 1'b0;
          end
          if (c == ZeroByte) begin
            zero_d    = 1'b1;
            hex_act_d = 1'b0;
          end else if (!star_q) begin
            if (c == StarByte) begin
              star_d    = 1'b1;
              star_ok_d = (fill_q <= FillW'(LineBufBytes - 3));
              hex_act_d = 1'b1;
              hex_d     = 8'h00;
            end else if (fill_q != '0) begin
              xor_d = xor_q ^ c;
            end
          end else if (hex_act_q) begin
            if (hd.valid) begin
              hex_d = {hex_q[3:0], hd.value};
            end else begin
              hex_act_d = 1'b0;
            end
          end
        end
      end else begin
        push_o.push             = 1'b1;
        push_o.res.checksum_ok  = star_q && star_ok_q && (xor_q == hex_q);
        push_o.res.is_gga       = hdr_q && (fill_q >= FillW'(HeaderLen));
        push_o.res.star_found   = star_q;
        push_o.res.line_length  = LenW'(fill_q);
        push_o.res.computed_sum = xor_q;
        push_o.res.received_sum = star_q ? hex_q : 8'h00;
        push_o.res.full_end     = !is_nl;
        fill_d    = '0;
        xor_d     = 8'h00;
        star_d    = 1'b0;
        star_ok_d = 1'b0;
        hex_d     = 8'h00;
        hex_act_d = 1'b0;
        hdr_d     = 1'b1;
        zero_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      xor_q     <= 8'h00;
      star_q    <= 1'b0;
      star_ok_q <= 1'b0;
      hex_q     <= 8'h00;
      hex_act_q <= 1'b0;
      hdr_q     <= 1'b1;
      zero_q    <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      xor_q     <= xor_d;
      star_q    <= star_d;
      star_ok_q <= star_ok_d;
      hex_q     <= hex_d;
      hex_act_q <= hex_act_d;
      hdr_q     <= hdr_d;
      zero_q    <= zero_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(LineBufBytes - 1))
    else $error("fill count beyond buffer");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |=> (fill_q == '0 && !star_q && !zero_q && hdr_q))
    else $error("line state not cleared after line end");

  a_hex_needs_star: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_act_q |-> star_q)
    else $error("hex run active without star");

endmodule

>>> hw/rtl/nlcc_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_out_buf
// two-entry result buffer, decouples output stall from the byte path
// ----------------------------------------------------------------------------
module nlcc_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nlcc_pkg::nlcc_push_t   push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output nlcc_pkg::nlcc_result_t res_o
);
  import nlcc_pkg::*;

  logic [1:0]   cnt_q, cnt_d;
  nlcc_result_t head_q, head_d;
  nlcc_result_t tail_q, tail_d;
  logic         pop;

  assign room_o      = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign res_o       = head_q;

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (pop && push_i.push) begin
      if (cnt_q == 2'd1) begin
        head_d = push_i.res;
      end else begin
        head_d = tail_q;
        tail_d = push_i.res;
      end
    end else if (push_i.push) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd0) begin
        head_d = push_i.res;
      end else begin
        tail_d = push_i.res;
      end
    end else if (pop) begin
      cnt_d  = cnt_q - 2'd1;
      head_d = tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> cnt_q != 2'd2)
    else $error("result pushed into full buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");

endmodule
